@@ rtl/core/motor_command_packet_framer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the motor command packet framer
// Implication checks, sampled on clk and switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_PACKET_FRAMER_TOP_MACROS_SVH
`define MOTOR_COMMAND_PACKET_FRAMER_TOP_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define MCPF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define MCPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/mcpf_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpf_pkg
// Shared types and frame constants for the motor command packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpf_pkg;

	localparam int BYTE_W      = 8;
	localparam int COUNT_W     = 4;
	localparam int PARAM_BUS_W = 64;

	localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hD5;
	localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h5D;
	localparam logic [BYTE_W-1:0] LEN_OFFSET = 8'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR1,
		ST_HDR2,
		ST_ID,
		ST_LEN,
		ST_INS,
		ST_PARAM,
		ST_SUM
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/motor_command_packet_framer_top.sv @@
// ----------------------------------------------------------------------------
// motor_command_packet_framer_top
// Frames one motor command into a serial byte stream with additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid / cmd_stall): one word carries motor_id,
//   instruction, param_count and param_bytes. A count above MAX_PARAMS is
//   clamped to MAX_PARAMS; parameter bytes beyond the count are ignored.
//   Frame channel (frame_valid / frame_stall): one frame byte per word, in
//   order D5, 5D, id, length, instruction, params..., checksum. last_byte
//   marks the checksum word. Length is count + 2; the checksum is the 8-bit
//   sum of id, length, instruction and the sent parameter bytes.
//   Start: an accepted command is latched as the sequencer enters ST_HDR1;
//   then the D5 byte enters the output register. A frame of n parameters
//   is n + 6 words. Throughput: a new command is taken in the same cycle
//   the checksum byte enters the output register, so unstalled frames run
//   back to back. The byte sequencer and its single 8-bit checksum adder
//   emit one frame byte per cycle while frame_stall is low.
//   Stall: frame_stall holds the output register; the sequencer waits and
//   cmd_stall stays high until the frame is complete.
//   Reset: arst_n clears the sequencer to idle and drops frame_valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_command_packet_framer_top_macros.svh"

module motor_command_packet_framer_top #(
	parameter int MAX_PARAMS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                cmd_valid,
	output logic                                     cmd_stall,
	input  wire logic [mcpf_pkg::BYTE_W-1:0]         motor_id,
	input  wire logic [mcpf_pkg::BYTE_W-1:0]         instruction,
	input  wire logic [mcpf_pkg::COUNT_W-1:0]        param_count,
	input  wire logic [mcpf_pkg::PARAM_BUS_W-1:0]    param_bytes,
	// frame channel
	output logic                                     frame_valid,
	input  wire logic                                frame_stall,
	output logic [mcpf_pkg::BYTE_W-1:0]              tx_byte,
	output logic                                     last_byte
);

	localparam int PARAM_W = MAX_PARAMS * mcpf_pkg::BYTE_W;

	// sequencer state
	mcpf_pkg::state_t state_q;
	mcpf_pkg::state_t state_d;

	// latched command
	logic [mcpf_pkg::BYTE_W-1:0]  id_q;
	logic [mcpf_pkg::BYTE_W-1:0]  ins_q;
	logic [mcpf_pkg::BYTE_W-1:0]  len_q;
	logic [PARAM_W-1:0]           param_q;
	logic [mcpf_pkg::COUNT_W-1:0] rem_q;

	// running checksum, fed by the one shared adder
	logic [mcpf_pkg::BYTE_W-1:0]  sum_q;

	// output register
	logic                         frame_valid_q;
	logic [mcpf_pkg::BYTE_W-1:0]  tx_byte_q;
	logic                         last_q;

	// control
	logic                         advance;
	logic                         cmd_accept;
	logic                         load;
	logic                         add_en;
	logic                         shift_en;
	logic                         last_d;
	logic [mcpf_pkg::BYTE_W-1:0]  byte_d;
	logic [mcpf_pkg::COUNT_W-1:0] cnt_sat;

	// Output register can take a new byte when empty or being drained.
	assign advance = !frame_valid_q || !frame_stall;

	// Accept in idle, or overlap with the checksum byte leaving the sequencer.
	assign cmd_stall  = !((state_q == mcpf_pkg::ST_IDLE) ||
		((state_q == mcpf_pkg::ST_SUM) && advance));
	assign cmd_accept = cmd_valid && !cmd_stall;

	// Clamp the parameter count.
	assign cnt_sat = (param_count > mcpf_pkg::COUNT_W'(MAX_PARAMS)) ?
		mcpf_pkg::COUNT_W'(MAX_PARAMS) : param_count;

	// Next state and byte select.
	always_comb begin
		state_d  = state_q;
		byte_d   = '0;
		last_d   = 1'b0;
		load     = 1'b0;
		add_en   = 1'b0;
		shift_en = 1'b0;
		unique case (state_q)
			mcpf_pkg::ST_IDLE: begin
				if (cmd_accept) begin
					state_d = mcpf_pkg::ST_HDR1;
				end
			end
			mcpf_pkg::ST_HDR1: begin
				byte_d = mcpf_pkg::HDR_FIRST;
				if (advance) begin
					load    = 1'b1;
					state_d = mcpf_pkg::ST_HDR2;
				end
			end
			mcpf_pkg::ST_HDR2: begin
				byte_d = mcpf_pkg::HDR_SECOND;
				if (advance) begin
					load    = 1'b1;
					state_d = mcpf_pkg::ST_ID;
				end
			end
			mcpf_pkg::ST_ID: begin
				byte_d = id_q;
				if (advance) begin
					load    = 1'b1;
					add_en  = 1'b1;
					state_d = mcpf_pkg::ST_LEN;
				end
			end
			mcpf_pkg::ST_LEN: begin
				byte_d = len_q;
				if (advance) begin
					load    = 1'b1;
					add_en  = 1'b1;
					state_d = mcpf_pkg::ST_INS;
				end
			end
			mcpf_pkg::ST_INS: begin
				byte_d = ins_q;
				if (advance) begin
					load    = 1'b1;
					add_en  = 1'b1;
					state_d = (rem_q == '0) ? mcpf_pkg::ST_SUM : mcpf_pkg::ST_PARAM;
				end
			end
			mcpf_pkg::ST_PARAM: begin
				byte_d = param_q[mcpf_pkg::BYTE_W-1:0];
				if (advance) begin
					load     = 1'b1;
					add_en   = 1'b1;
					shift_en = 1'b1;
					if (rem_q == mcpf_pkg::COUNT_W'(1)) begin
						state_d = mcpf_pkg::ST_SUM;
					end
				end
			end
			mcpf_pkg::ST_SUM: begin
				byte_d = sum_q;
				last_d = 1'b1;
				if (advance) begin
					load    = 1'b1;
					state_d = cmd_accept ? mcpf_pkg::ST_HDR1 : mcpf_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command latch, parameter shifter and checksum accumulator.
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			id_q    <= motor_id;
			ins_q   <= instruction;
			len_q   <= mcpf_pkg::BYTE_W'(cnt_sat) + mcpf_pkg::LEN_OFFSET;
			param_q <= param_bytes[PARAM_W-1:0];
			rem_q   <= cnt_sat;
			sum_q   <= '0;
		end else begin
			if (shift_en) begin
				param_q <= param_q >> mcpf_pkg::BYTE_W;
				rem_q   <= rem_q - mcpf_pkg::COUNT_W'(1);
			end
			if (add_en) begin
				sum_q <= sum_q + byte_d;
			end
		end
	end

	// Output register: hold while stalled, drop valid once drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (load) begin
			frame_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_byte_q <= byte_d;
			last_q    <= last_d;
		end
	end

	assign frame_valid = frame_valid_q;
	assign tx_byte     = tx_byte_q;
	assign last_byte   = last_q;

	// Assertions
	`MCPF_ASSERT_NEXT(a_accept_starts_frame, cmd_accept, state_q == mcpf_pkg::ST_HDR1, "accepted command did not start a frame")
	`MCPF_ASSERT_NOW(a_sum_cleared_at_start, state_q == mcpf_pkg::ST_HDR1, sum_q == '0, "checksum not cleared at frame start")
	`MCPF_ASSERT_NOW(a_param_count_live, state_q == mcpf_pkg::ST_PARAM, rem_q != '0, "parameter state with no bytes left")
	`MCPF_ASSERT_NOW(a_last_ends_frame, frame_valid && last_byte, (state_q == mcpf_pkg::ST_IDLE) || (state_q == mcpf_pkg::ST_HDR1), "checksum byte shown mid-frame")

endmodule

`default_nettype wire
